/* rtl/mwlm_pkg.sv */
// Shared types, constants and arithmetic steps of the muscle wrap length and moment arm block.
// Used by every module in rtl; depends on nothing else.
package mwlm_pkg;

   localparam int DIST_W       = 16;
   localparam int ANGLE_W      = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int DIV_STEPS    = 30;
   localparam int GUARD        = 14;
   localparam int CW           = 36;
   localparam int STEP_W       = 5;
   localparam int LE_W         = 34;
   localparam int REM_W        = 35;
   localparam int SQRT_W       = 34;

   localparam logic signed [CW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic signed [CW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic [29:0]          GAIN_Q30    = 30'd652032874;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_ORIGIN    = 2'd0;
   localparam logic [1:0] REG_INSERTION = 2'd1;
   localparam logic [1:0] REG_RADIUS    = 2'd2;
   localparam logic [1:0] REG_FLEXOR    = 2'd3;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
   } cordic_type;

   // Item data that rides alongside the arithmetic through the cell chains.
   typedef struct packed {
      logic        neg;
      logic        wraps;
      logic [31:0] arc_prod;
      logic [30:0] ay0;
      logic [16:0] len;
   } side_type;

   typedef struct packed {
      logic [LE_W-1:0]      le;
      logic [REM_W-1:0]     rem;
      logic [DIV_STEPS-1:0] q;
      logic                 full;
      logic                 zero;
   } div_type;

   typedef struct packed {
      logic [DIST_W-1:0] origin;
      logic [DIST_W-1:0] insertion;
      logic [DIST_W-1:0] radius;
      logic              flexor;
   } cfg_type;

   typedef struct packed {
      logic [15:0]       thr;
      logic [DIST_W-1:0] otan;
      logic [DIST_W-1:0] itan;
   } derived_type;

   localparam logic signed [CW-1:0] ATAN_TAB [0:10] = '{
      36'sd843314857, 36'sd497837829, 36'sd263043837, 36'sd133525159, 36'sd67021687,
      36'sd33543516, 36'sd16775851, 36'sd8388437, 36'sd4194283, 36'sd2097149,
      36'sd1048576
   };

   // atan(2^-k) in 2^-30 rad; beyond the table the angle equals 2^-k.
   function automatic logic signed [CW-1:0] atan_step(input logic [STEP_W-1:0] k);
      logic signed [CW-1:0] unit;
      unit = 36'sh0_4000_0000;
      if (k < STEP_W'(11)) begin
         atan_step = ATAN_TAB[k[3:0]];
      end else begin
         atan_step = unit >>> k;
      end
   endfunction

   // One CORDIC micro-rotation; rotation mode steers on z, vectoring mode on y.
   function automatic cordic_type cordic_step(input cordic_type v, input logic [STEP_W-1:0] k,
                                             input logic rotate);
      cordic_type           res;
      logic signed [CW-1:0] xv;
      logic signed [CW-1:0] yv;
      logic signed [CW-1:0] zv;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] at;
      logic                 up;
      xv = v.x;
      yv = v.y;
      zv = v.z;
      dx = yv >>> k;
      dy = xv >>> k;
      at = atan_step(k);
      up = rotate ? (zv >= 0) : (yv <= 0);
      if (up) begin
         res.x = xv - dx;
         res.y = yv + dy;
         res.z = zv - at;
      end else begin
         res.x = xv + dx;
         res.y = yv - dy;
         res.z = zv + at;
      end
      return res;
   endfunction

   // One restoring division step: one quotient bit.
   function automatic div_type div_step(input div_type v);
      div_type          res;
      logic [REM_W-1:0] shifted;
      res     = v;
      shifted = v.rem << 1;
      if (shifted >= REM_W'(v.le)) begin
         res.rem = shifted - REM_W'(v.le);
         res.q   = {v.q[DIV_STEPS-2:0], 1'b1};
      end else begin
         res.rem = shifted;
         res.q   = {v.q[DIV_STEPS-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

/* rtl/mwlm_cordic_cell.sv */
// One registered CORDIC cell of the rotation and vectoring chains.
// Depends on mwlm_pkg.
module mwlm_cordic_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [mwlm_pkg::STEP_W-1:0]   step_idx,
   input  logic                          rotate,
   input  logic                          in_valid,
   input  mwlm_pkg::cordic_type          in_vec,
   input  mwlm_pkg::side_type            in_side,
   output logic                          out_valid,
   output mwlm_pkg::cordic_type          out_vec,
   output mwlm_pkg::side_type            out_side
);
   import mwlm_pkg::*;

   logic       valid_ff;
   cordic_type vec_ff;
   cordic_type vec_in;
   side_type   side_ff;

   always_comb begin
      vec_in = cordic_step(in_vec, step_idx, rotate);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      vec_ff  <= vec_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/mwlm_div_cell.sv */
// One registered cell of the restoring divider chain, one quotient bit per cell.
// Depends on mwlm_pkg.
module mwlm_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  mwlm_pkg::div_type  in_div,
   input  mwlm_pkg::side_type in_side,
   output logic               out_valid,
   output mwlm_pkg::div_type  out_div,
   output mwlm_pkg::side_type out_side
);
   import mwlm_pkg::*;

   logic     valid_ff;
   div_type  div_ff;
   div_type  div_in;
   side_type side_ff;

   always_comb begin
      div_in = div_step(in_div);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      div_ff  <= div_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

/* rtl/mwlm_derive.sv */
// Sequencer that derives the wrap threshold and tangent lengths from the registers.
// Depends on mwlm_pkg; one square root bit or one CORDIC step per cycle.
module mwlm_derive (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  mwlm_pkg::cfg_type     cfg,
   output mwlm_pkg::derived_type derived,
   output logic                  busy
);
   import mwlm_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_SQRT  = 3'd2;
   localparam logic [2:0] S_ROUND = 3'd3;
   localparam logic [2:0] S_VEC   = 3'd4;
   localparam logic [2:0] S_THR   = 3'd5;

   logic [2:0]           state_ff, state_in;
   logic                 sel_ff, sel_in;
   logic [STEP_W-1:0]    cnt_ff, cnt_in;
   logic [SQRT_W-1:0]    sq_n_ff, sq_n_in;
   logic [SQRT_W-1:0]    sq_res_ff, sq_res_in;
   cordic_type           vec_ff, vec_in;
   logic signed [CW-1:0] ang1_ff, ang1_in;
   logic signed [CW-1:0] ang2_ff, ang2_in;
   derived_type          der_ff, der_in;

   logic [DIST_W-1:0]    dist_val;
   logic [DIST_W-1:0]    rad;
   logic [2*DIST_W-1:0]  dsq;
   logic [2*DIST_W-1:0]  rsq;
   logic [SQRT_W-1:0]    sq_bit;
   logic [SQRT_W-1:0]    trial;
   logic [SQRT_W-1:0]    tan_full;
   cordic_type           vec_step;
   logic signed [CW-1:0] ang_new;
   logic signed [CW-1:0] thr_raw;
   logic signed [CW-1:0] thr_rnd;

   always_comb begin
      dist_val = sel_ff ? cfg.insertion : cfg.origin;
      rad      = (cfg.radius > dist_val) ? dist_val : cfg.radius;
      dsq      = dist_val * dist_val;
      rsq      = rad * rad;
      sq_bit   = (SQRT_W'(1) << (2 * DIST_W - 2)) >> {cnt_ff, 1'b0};
      trial    = sq_res_ff + sq_bit;
      tan_full = (sq_n_ff > sq_res_ff) ? sq_res_ff + SQRT_W'(1) : sq_res_ff;
      vec_step = cordic_step(vec_ff, cnt_ff, 1'b0);
      ang_new  = (vec_step.z < 0) ? '0 : vec_step.z;
      thr_raw  = PI_Q30 - ang1_ff - ang2_ff;
      if (thr_raw < 0) begin
         thr_raw = '0;
      end
      thr_rnd  = (thr_raw + (CW'(1) <<< 16)) >>> 17;

      state_in  = state_ff;
      sel_in    = sel_ff;
      cnt_in    = cnt_ff;
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      vec_in    = vec_ff;
      ang1_in   = ang1_ff;
      ang2_in   = ang2_ff;
      der_in    = der_ff;

      case (state_ff)
         S_IDLE: begin
            state_in = S_IDLE;
         end
         S_LOAD: begin
            sq_n_in   = SQRT_W'(dsq) - SQRT_W'(rsq);
            sq_res_in = '0;
            cnt_in    = '0;
            state_in  = S_SQRT;
         end
         S_SQRT: begin
            if (sq_n_ff >= trial) begin
               sq_n_in   = sq_n_ff - trial;
               sq_res_in = (sq_res_ff >> 1) + sq_bit;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(DIST_W - 1)) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            if (sel_ff) begin
               der_in.itan = tan_full[DIST_W-1:0];
            end else begin
               der_in.otan = tan_full[DIST_W-1:0];
            end
            vec_in.x = CW'({rad, GUARD'(0)});
            vec_in.y = CW'({tan_full[DIST_W-1:0], GUARD'(0)});
            vec_in.z = '0;
            cnt_in   = '0;
            state_in = S_VEC;
         end
         S_VEC: begin
            vec_in = vec_step;
            cnt_in = cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               if (sel_ff) begin
                  ang2_in  = ang_new;
                  state_in = S_THR;
               end else begin
                  ang1_in  = ang_new;
                  sel_in   = 1'b1;
                  state_in = S_LOAD;
               end
            end
         end
         S_THR: begin
            der_in.thr = thr_rnd[15:0];
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (restart) begin
         state_in = S_LOAD;
         sel_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
      cnt_ff    <= cnt_in;
      sq_n_ff   <= sq_n_in;
      sq_res_ff <= sq_res_in;
      vec_ff    <= vec_in;
      ang1_ff   <= ang1_in;
      ang2_ff   <= ang2_in;
      der_ff    <= der_in;
   end

   assign derived = der_ff;
   assign busy    = (state_ff != S_IDLE);

endmodule

/* rtl/muscle_wrap_length_moment_arm.sv */
// Top level of the muscle wrap length and moment arm block: register port and item pipeline.
// Depends on mwlm_pkg, mwlm_cordic_cell, mwlm_div_cell and mwlm_derive.
//
// One joint angle in, one result out: the muscle path length, the moment arm and a flag
// that says whether the path wraps round the joint capsule. The block takes a new angle in
// every clock cycle in which start is high and busy is low, and each result appears on the
// rsp_ ports with rsp_strobe high for exactly one cycle; results leave in the order the
// angles came in. The receiver must take every result in the cycle in which it is shown,
// as the block has no way to hold it back. The pipeline is a chain of cells: 16 rotation
// CORDIC cells for cos and sin, 16 vectoring CORDIC cells for the straight-path length and
// 30 divider cells for the sine ratio, with the registered stages A to H around them.
// After reset and after every register write a sequencer works out the wrap threshold and
// the two tangent lengths one square root bit or one CORDIC step per cycle; busy stays high
// while it works and no angle is taken meanwhile. Registers may only be written when no
// result is outstanding.
module muscle_wrap_length_moment_arm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [mwlm_pkg::ANGLE_W-1:0] req_joint_angle,
   output logic                             rsp_strobe,
   output logic [mwlm_pkg::DIST_W:0]        rsp_muscle_length,
   output logic [mwlm_pkg::DIST_W-1:0]      rsp_moment_arm,
   output logic                             rsp_wraps,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [3:0]                       paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import mwlm_pkg::*;

   localparam int LATENCY = 2 * CORDIC_STEPS + DIV_STEPS + 8;

   // Registers on the configuration port.
   logic [DIST_W-1:0] origin_ff, insertion_ff, radius_ff;
   logic              flexor_ff;
   logic              cfg_write;
   cfg_type           cfg;
   derived_type       derived;
   logic              accept;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff    <= DIST_W'(6554);
         insertion_ff <= DIST_W'(6554);
         radius_ff    <= DIST_W'(1311);
         flexor_ff    <= 1'b1;
      end else if (cfg_write) begin
         case (paddr[3:2])
            REG_ORIGIN:    origin_ff    <= pwdata[DIST_W-1:0];
            REG_INSERTION: insertion_ff <= pwdata[DIST_W-1:0];
            REG_RADIUS:    radius_ff    <= pwdata[DIST_W-1:0];
            REG_FLEXOR:    flexor_ff    <= pwdata[0];
            default:       flexor_ff    <= flexor_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_ORIGIN:    prdata = 32'(origin_ff);
         REG_INSERTION: prdata = 32'(insertion_ff);
         REG_RADIUS:    prdata = 32'(radius_ff);
         REG_FLEXOR:    prdata = 32'(flexor_ff);
         default:       prdata = '0;
      endcase
   end

   assign cfg = '{origin: origin_ff, insertion: insertion_ff, radius: radius_ff,
                  flexor: flexor_ff};

   // The derived values are recomputed after reset and after every register write.
   mwlm_derive u_derive (
      .clock   (clock),
      .reset   (reset),
      .restart (cfg_write),
      .cfg     (cfg),
      .derived (derived),
      .busy    (busy)
   );

   assign accept = start & ~busy;

   // Stage A: mirror the angle for an extensor and decide whether the path wraps.
   logic                 a_valid_ff;
   logic signed [16:0]   a_angle_ff, a_angle_in;
   logic                 a_wraps_ff, a_wraps_in;
   logic signed [17:0]   thr_s;

   always_comb begin
      thr_s      = $signed({2'b00, derived.thr});
      a_angle_in = flexor_ff ? 17'(req_joint_angle) : -17'(req_joint_angle);
      a_wraps_in = (18'(a_angle_in) < thr_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_angle_ff <= a_angle_in;
      a_wraps_ff <= a_wraps_in;
   end

   // Stage B: bring the angle into the right half plane and form the arc product. A
   // straight path only occurs for angles at or above the threshold, which is never
   // negative, so a single subtraction of a full turn is enough.
   logic                 b_valid_ff;
   cordic_type           b_vec_ff, b_vec_in;
   side_type             b_side_ff, b_side_in;
   logic signed [CW-1:0] r0, r1, rf;
   logic                 neg;
   logic signed [17:0]   wrap_span;

   always_comb begin
      r0 = CW'(a_angle_ff) <<< 17;
      r1 = (r0 > PI_Q30) ? r0 - TWO_PI_Q30 : r0;
      if (r1 > HALF_PI_Q30) begin
         rf  = PI_Q30 - r1;
         neg = 1'b1;
      end else if (r1 < -HALF_PI_Q30) begin
         rf  = -PI_Q30 - r1;
         neg = 1'b1;
      end else begin
         rf  = r1;
         neg = 1'b0;
      end
      wrap_span          = thr_s - 18'(a_angle_ff);
      b_vec_in.x         = CW'(GAIN_Q30);
      b_vec_in.y         = '0;
      b_vec_in.z         = rf;
      b_side_in          = '0;
      b_side_in.neg      = neg;
      b_side_in.wraps    = a_wraps_ff;
      b_side_in.arc_prod = radius_ff * wrap_span[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_vec_ff  <= b_vec_in;
      b_side_ff <= b_side_in;
   end

   // Rotation chain: cos and sin of the folded angle.
   logic       rot_valid [0:CORDIC_STEPS];
   cordic_type rot_vec   [0:CORDIC_STEPS];
   side_type   rot_side  [0:CORDIC_STEPS];

   assign rot_valid[0] = b_valid_ff;
   assign rot_vec[0]   = b_vec_ff;
   assign rot_side[0]  = b_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      mwlm_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(i)),
         .rotate    (1'b1),
         .in_valid  (rot_valid[i]),
         .in_vec    (rot_vec[i]),
         .in_side   (rot_side[i]),
         .out_valid (rot_valid[i+1]),
         .out_vec   (rot_vec[i+1]),
         .out_side  (rot_side[i+1])
      );
   end

   // Stage C: scale cos and sin by the insertion distance.
   logic               c_valid_ff;
   logic signed [48:0] c_pc_ff, c_pc_in, c_ps_ff, c_ps_in;
   side_type           c_side_ff;
   logic signed [31:0] cos_v, sin_v;

   always_comb begin
      cos_v   = rot_vec[CORDIC_STEPS].x[31:0];
      sin_v   = rot_vec[CORDIC_STEPS].y[31:0];
      if (rot_side[CORDIC_STEPS].neg) begin
         cos_v = -cos_v;
      end
      c_pc_in = $signed({1'b0, insertion_ff}) * cos_v;
      c_ps_in = $signed({1'b0, insertion_ff}) * sin_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= rot_valid[CORDIC_STEPS];
      end
      c_pc_ff   <= c_pc_in;
      c_ps_ff   <= c_ps_in;
      c_side_ff <= rot_side[CORDIC_STEPS];
   end

   // Stage D: the insertion point relative to the origin line, folded to the first quadrant.
   logic               d_valid_ff;
   cordic_type         d_vec_ff, d_vec_in;
   side_type           d_side_ff, d_side_in;
   logic signed [48:0] xw, yw, ax, ay;

   always_comb begin
      xw = $signed({19'b0, origin_ff, 14'b0}) + (c_pc_ff >>> (30 - GUARD));
      yw = c_ps_ff >>> (30 - GUARD);
      ax = (xw < 0) ? -xw : xw;
      ay = (yw < 0) ? -yw : yw;
      d_vec_in.x    = ax[CW-1:0];
      d_vec_in.y    = ay[CW-1:0];
      d_vec_in.z    = '0;
      d_side_in     = c_side_ff;
      d_side_in.ay0 = ay[30:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= c_valid_ff;
      end
      d_vec_ff  <= d_vec_in;
      d_side_ff <= d_side_in;
   end

   // Vectoring chain: magnitude of the straight path, times the CORDIC gain.
   logic       vec_valid [0:CORDIC_STEPS];
   cordic_type vec_vec   [0:CORDIC_STEPS];
   side_type   vec_side  [0:CORDIC_STEPS];

   assign vec_valid[0] = d_valid_ff;
   assign vec_vec[0]   = d_vec_ff;
   assign vec_side[0]  = d_side_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
      mwlm_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (STEP_W'(i)),
         .rotate    (1'b0),
         .in_valid  (vec_valid[i]),
         .in_vec    (vec_vec[i]),
         .in_side   (vec_side[i]),
         .out_valid (vec_valid[i+1]),
         .out_vec   (vec_vec[i+1]),
         .out_side  (vec_side[i+1])
      );
   end

   // Stage E: gain removal, split into a high and a low partial product.
   logic               e_valid_ff;
   logic [48:0]        e_ph_ff, e_ph_in;
   logic [44:0]        e_pl_ff, e_pl_in;
   side_type           e_side_ff;
   logic [LE_W-1:0]    mag;

   always_comb begin
      mag     = (vec_vec[CORDIC_STEPS].x < 0) ? '0 : vec_vec[CORDIC_STEPS].x[LE_W-1:0];
      e_ph_in = mag[LE_W-1:15] * GAIN_Q30;
      e_pl_in = mag[14:0] * GAIN_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else begin
         e_valid_ff <= vec_valid[CORDIC_STEPS];
      end
      e_ph_ff   <= e_ph_in;
      e_pl_ff   <= e_pl_in;
      e_side_ff <= vec_side[CORDIC_STEPS];
   end

   // Stage F: straight-path length with guard bits, and its rounded, saturated form.
   logic            f_valid_ff;
   logic [LE_W-1:0] f_le_ff, f_le_in;
   side_type        f_side_ff, f_side_in;
   logic [48:0]     gain_sum;
   logic [LE_W:0]   len_rnd;

   always_comb begin
      gain_sum  = e_ph_ff + 49'(e_pl_ff >> 15);
      f_le_in   = gain_sum[48:15];
      len_rnd   = ((LE_W + 1)'(f_le_in) + (LE_W + 1)'(1 << (GUARD - 1))) >> GUARD;
      f_side_in = e_side_ff;
      if (len_rnd > (LE_W + 1)'(17'h1FFFF)) begin
         f_side_in.len = 17'h1FFFF;
      end else begin
         f_side_in.len = len_rnd[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= e_valid_ff;
      end
      f_le_ff   <= f_le_in;
      f_side_ff <= f_side_in;
   end

   // Stage G: set up the sine ratio division; a ratio of one or more is pinned at one.
   logic     g_valid_ff;
   div_type  g_div_ff, g_div_in;
   side_type g_side_ff;

   always_comb begin
      g_div_in.le   = f_le_ff;
      g_div_in.rem  = REM_W'(f_side_ff.ay0);
      g_div_in.q    = '0;
      g_div_in.full = (REM_W'(f_side_ff.ay0) >= REM_W'(f_le_ff));
      g_div_in.zero = (f_le_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else begin
         g_valid_ff <= f_valid_ff;
      end
      g_div_ff  <= g_div_in;
      g_side_ff <= f_side_ff;
   end

   // Divider chain: one quotient bit per cell.
   logic     div_valid [0:DIV_STEPS];
   div_type  div_val   [0:DIV_STEPS];
   side_type div_side  [0:DIV_STEPS];

   assign div_valid[0] = g_valid_ff;
   assign div_val[0]   = g_div_ff;
   assign div_side[0]  = g_side_ff;

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      mwlm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_div    (div_val[i]),
         .in_side   (div_side[i]),
         .out_valid (div_valid[i+1]),
         .out_div   (div_val[i+1]),
         .out_side  (div_side[i+1])
      );
   end

   // Stage H: moment arm from the ratio, the wrapped length, and the output register.
   logic                 out_strobe_ff;
   logic [DIST_W:0]      out_len_ff, out_len_in;
   logic [DIST_W-1:0]    out_arm_ff, out_arm_in;
   logic                 out_wraps_ff;
   div_type              div_last;
   side_type             side_last;
   logic [DIV_STEPS:0]   q_final;
   logic [DIV_STEPS+DIST_W:0] arm_prod;
   logic [DIST_W:0]      arm_rnd;
   logic [19:0]          arc;
   logic [20:0]          wrap_len;

   always_comb begin
      div_last  = div_val[DIV_STEPS];
      side_last = div_side[DIV_STEPS];
      q_final   = div_last.full ? ((DIV_STEPS + 1)'(1) << DIV_STEPS)
                                : {1'b0, div_last.q};
      arm_prod  = origin_ff * q_final + (DIV_STEPS + DIST_W + 1)'(1 << (DIV_STEPS - 1));
      arm_rnd   = arm_prod[DIV_STEPS+DIST_W:DIV_STEPS];
      arc       = 20'((33'(side_last.arc_prod) + 33'd4096) >> 13);
      wrap_len  = 21'(derived.otan) + 21'(derived.itan) + 21'(arc);
      if (side_last.wraps) begin
         out_arm_in = radius_ff;
         out_len_in = (wrap_len > 21'h1FFFF) ? 17'h1FFFF : wrap_len[16:0];
      end else begin
         out_len_in = side_last.len;
         if (div_last.zero) begin
            out_arm_in = '0;
         end else if (arm_rnd > (DIST_W + 1)'(16'hFFFF)) begin
            out_arm_in = 16'hFFFF;
         end else begin
            out_arm_in = arm_rnd[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= div_valid[DIV_STEPS];
      end
      out_len_ff   <= out_len_in;
      out_arm_ff   <= out_arm_in;
      out_wraps_ff <= side_last.wraps;
   end

   assign rsp_strobe        = out_strobe_ff;
   assign rsp_muscle_length = out_len_ff;
   assign rsp_moment_arm    = out_arm_ff;
   assign rsp_wraps         = out_wraps_ff;

`ifndef ASSERT_OFF
   // Every accepted angle yields a result after the fixed pipeline latency.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("result missing after accepted angle");

   // A wrapped path has the capsule radius as its moment arm.
   a_wrap_arm : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_wraps |-> rsp_moment_arm == radius_ff)
      else $error("wrapped moment arm differs from radius");

   // A straight path never has a moment arm beyond the origin distance.
   a_straight_arm : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_wraps |-> rsp_moment_arm <= origin_ff)
      else $error("straight moment arm exceeds origin distance");

   // A register write starts a fresh derivation.
   a_write_busy : assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> busy)
      else $error("register write did not start derivation");
`endif

endmodule

/* dv/muscle_wrap_length_moment_arm_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for muscle_wrap_length_moment_arm: angles in, length, arm and wrap out.
// Depends on rtl/mwlm_pkg.sv and rtl/muscle_wrap_length_moment_arm.sv.
module muscle_wrap_length_moment_arm_test;
   import mwlm_pkg::*;

   // Predicts muscle geometry from the register settings and keeps the results still owed.
   class muscle_geometry_board;
      typedef struct {
         logic [16:0] len;
         logic [15:0] arm;
         logic        wraps;
      } geometry_type;

      geometry_type      owed[$];
      int                errors;
      longint unsigned   origin, insertion, radius, flexor;
      longint            thr;
      longint unsigned   otan, itan;

      function new();
         errors = 0;
         origin = 6554;
         insertion = 6554;
         radius = 1311;
         flexor = 1;
         recompute();
      endfunction

      function longint atan_of(int k);
         if (k < 11) return longint'(ATAN_TAB[k]);
         if (k <= 30) return longint'(1) << (30 - k);
         return 0;
      endfunction

      function longint unsigned root_rounded(longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         if (n > res) res++;
         return res;
      endfunction

      // Vectoring: y is driven to zero, x grows to gain times the magnitude.
      function void vector_mode(inout longint x, inout longint y, inout longint z);
         longint dx, dy;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y > 0) begin
               x += dx; y -= dy; z += atan_of(k);
            end else begin
               x -= dx; y += dy; z -= atan_of(k);
            end
         end
      endfunction

      function void rotate_mode(input longint b, output longint c, output longint s);
         longint x, y, z, dx, dy;
         x = longint'(GAIN_Q30);
         y = 0;
         z = b;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_of(k);
            end else begin
               x += dx; y -= dy; z += atan_of(k);
            end
         end
         c = x;
         s = y;
      endfunction

      function longint wrap_angle(input longint unsigned d, output longint unsigned t);
         longint unsigned r;
         longint x, y, z;
         r = (radius > d) ? d : radius;
         t = root_rounded(d * d - r * r);
         x = longint'(r << GUARD);
         y = longint'(t << GUARD);
         z = 0;
         vector_mode(x, y, z);
         return (z < 0) ? 0 : z;
      endfunction

      function void recompute();
         longint a1, a2, t;
         a1 = wrap_angle(origin, otan);
         a2 = wrap_angle(insertion, itan);
         t = longint'(PI_Q30) - a1 - a2;
         if (t < 0) t = 0;
         thr = (t + (longint'(1) << 16)) >>> 17;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_ORIGIN:    origin = value[15:0];
            REG_INSERTION: insertion = value[15:0];
            REG_RADIUS:    radius = value[15:0];
            REG_FLEXOR:    flexor = value[0];
            default: ;
         endcase
         recompute();
      endfunction

      function longint unsigned strip_gain(longint unsigned m);
         longint unsigned g;
         g = longint'(GAIN_Q30);
         return ((m >> 15) * g + (((m & 64'h7FFF) * g) >> 15)) >> 15;
      endfunction

      // Notes an accepted angle and queues the geometry it must produce.
      function void note_angle(logic signed [15:0] angle);
         geometry_type    e;
         longint          a, r, c, s, x, y, ax, ay, z, pi, two_pi;
         longint unsigned len, arm, w, le, ay0, q, rem;
         bit              neg;
         pi = longint'(PI_Q30);
         two_pi = 2 * pi;
         a = angle;
         if (flexor == 0) a = -a;
         e.wraps = (a < thr);
         if (e.wraps) begin
            w = longint'(thr - a);
            len = otan + itan + ((radius * w + 4096) >> 13);
            arm = radius;
         end else begin
            // A straight path has a non-negative angle here, as the threshold is never negative.
            r = (a << 17) % two_pi;
            neg = 0;
            if (r > pi) r -= two_pi;
            if (r > longint'(HALF_PI_Q30)) begin
               r = pi - r; neg = 1;
            end else if (r < -longint'(HALF_PI_Q30)) begin
               r = -pi - r; neg = 1;
            end
            rotate_mode(r, c, s);
            if (neg) c = -c;
            x = longint'(origin << GUARD) + ((longint'(insertion) * c) >>> (30 - GUARD));
            y = (longint'(insertion) * s) >>> (30 - GUARD);
            ax = (x < 0) ? -x : x;
            ay = (y < 0) ? -y : y;
            ay0 = ay;
            z = 0;
            vector_mode(ax, ay, z);
            le = strip_gain((ax < 0) ? 0 : ax);
            len = (le + (64'd1 << (GUARD - 1))) >> GUARD;
            if (le == 0) begin
               arm = 0;
            end else begin
               q = ay0 / le;
               if (q >= 1) begin
                  q = 64'd1 << 30;
               end else begin
                  rem = ay0 % le;
                  for (int k = 0; k < 30; k++) begin
                     rem = rem << 1;
                     q = q << 1;
                     if (rem >= le) begin
                        rem -= le; q |= 1;
                     end
                  end
               end
               arm = (origin * q + (64'd1 << 29)) >> 30;
            end
         end
         if (len > 64'h1FFFF) len = 64'h1FFFF;
         if (arm > 64'hFFFF) arm = 64'hFFFF;
         e.len = len[16:0];
         e.arm = arm[15:0];
         owed = {owed, e};
      endfunction

      function void check_result(logic [16:0] len, logic [15:0] arm, logic wraps);
         geometry_type e;
         if (owed.size() == 0) begin
            $display("%0t: result with nothing outstanding: len %0d arm %0d wraps %0d",
                     $time, len, arm, wraps);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (len !== e.len) begin
            $display("%0t: muscle_length expected %0d actual %0d", $time, e.len, len);
            errors++;
         end
         if (arm !== e.arm) begin
            $display("%0t: moment_arm expected %0d actual %0d", $time, e.arm, arm);
            errors++;
         end
         if (wraps !== e.wraps) begin
            $display("%0t: wraps expected %0d actual %0d", $time, e.wraps, wraps);
            errors++;
         end
      endfunction
   endclass

   localparam int LATENCY = 69;

   logic                clock = 0;
   logic                reset = 1;
   logic                start = 0;
   logic                busy;
   logic signed [15:0]  req_joint_angle = 0;
   logic                rsp_strobe;
   logic [16:0]         rsp_muscle_length;
   logic [15:0]         rsp_moment_arm;
   logic                rsp_wraps;
   logic                psel = 0, penable = 0, pwrite = 0;
   logic [3:0]          paddr = 0;
   logic [31:0]         pwdata = 0;
   logic [31:0]         prdata;
   logic                pready;

   muscle_geometry_board board = new();

   muscle_wrap_length_moment_arm u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_joint_angle(req_joint_angle),
      .rsp_strobe(rsp_strobe), .rsp_muscle_length(rsp_muscle_length),
      .rsp_moment_arm(rsp_moment_arm), .rsp_wraps(rsp_wraps),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #10 clock = ~clock;

   // Results cannot be held off, so every strobed cycle is checked at the closing edge.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         board.check_result(rsp_muscle_length, rsp_moment_arm, rsp_wraps);
      end
   end

   // Mostly back-to-back transfers, some short pauses and the odd long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(20, 90);
   endfunction

   // Called at a falling edge; returns at a falling edge after the transfer and any pause.
   task automatic send_angle(input logic signed [15:0] angle);
      int gap;
      start = 1;
      req_joint_angle = angle;
      do @(posedge clock); while (busy);
      board.note_angle(angle);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start = 0;
         repeat (gap) begin
            req_joint_angle = 16'($urandom);
            @(negedge clock);
         end
      end
   endtask

   // Waits for the pipeline to drain, then lets the derivation of the last write settle.
   task automatic drain();
      start = 0;
      while (board.owed.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // A write in a setup phase and an access phase; the register takes the value on the access-phase edge.
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      drain();
      psel = 1;
      pwrite = 1;
      penable = 0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1;
      @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      psel = 0;
      penable = 0;
      pwrite = 0;
   endtask

   task automatic set_geometry(input int o, input int i, input int r, input bit f);
      write_reg(REG_ORIGIN, {16'($urandom), 16'(o)});
      write_reg(REG_INSERTION, {16'($urandom), 16'(i)});
      write_reg(REG_RADIUS, {16'($urandom), 16'(r)});
      write_reg(REG_FLEXOR, {31'($urandom), f});
   endtask

   // Random angles: the full range, a band round the wrap threshold and moderate bends.
   task automatic random_angles(input int count);
      int          roll;
      longint      edge_angle;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 9);
         edge_angle = (board.flexor != 0) ? board.thr : -board.thr;
         if (roll < 5) send_angle(16'($urandom));
         else if (roll < 8) send_angle(16'(edge_angle + $urandom_range(0, 128) - 64));
         else send_angle(16'($urandom_range(0, 8000)) - 16'sd4000);
         // Once per phase the sender holds back until every result is home.
         if (n == count / 2) begin
            start = 0;
            while (board.owed.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 0;

      // Directed angles at the reset geometry: extremes, zero, and both sides of the
      // threshold, plus half and quarter turns that exercise the angle reduction.
      send_angle(16'sh8000);
      send_angle(16'sh7FFF);
      send_angle(16'sd0);
      send_angle(-16'sd1);
      send_angle(16'sd1);
      send_angle(16'(board.thr));
      send_angle(16'(board.thr - 1));
      send_angle(16'(board.thr + 1));
      send_angle(16'sd25736);
      send_angle(-16'sd25736);
      send_angle(16'sd12868);
      send_angle(-16'sd14064);
      send_angle(16'sh5555);
      send_angle(16'shAAAA);
      random_angles(130);

      // Smallest distances with no capsule at all.
      set_geometry(1, 1, 0, 1);
      send_angle(16'sd0);
      send_angle(16'sd25736);
      random_angles(130);

      // Largest distances, a near-full capsule, extensor mirroring.
      set_geometry(65535, 65535, 65534, 0);
      send_angle(16'sh8000);
      send_angle(16'sh7FFF);
      random_angles(130);

      // Radius beyond one distance and equal to the other: clamped tangents.
      set_geometry(65535, 1, 65535, 1);
      random_angles(130);

      // Equal arms and no capsule: a straight fold to zero length.
      set_geometry(40000, 40000, 0, 1);
      send_angle(16'sd25736);
      send_angle(16'sd25735);
      send_angle(-16'sd25736);
      random_angles(130);

      for (int p = 0; p < 4; p++) begin
         int o, i;
         o = $urandom_range(1, 65535);
         i = $urandom_range(1, 65535);
         set_geometry(o, i, $urandom_range(0, ((o < i) ? o : i) - 1),
                      1'($urandom_range(0, 1)));
         random_angles(130);
      end

      start = 0;
      while (board.owed.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (board.errors == 0) begin
         $display("muscle_wrap_length_moment_arm_test: PASS");
      end else begin
         $display("muscle_wrap_length_moment_arm_test: FAIL");
      end
      $finish;
   end

   // This timeout ends the run with a failure if it has not finished first.
   initial begin
      #20_000_000;
      $display("muscle_wrap_length_moment_arm_test: FAIL");
      $finish;
   end

endmodule
